// File: src/erbf_pkg.sv
// ----------------------------------------------------------------------------
// erbf_pkg
// Shared types, register indexes, reset values and saturating helpers for the
// event-rate bias feedback core.
// ----------------------------------------------------------------------------
package erbf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_RATE_LOW   = 3'd0;
    localparam logic [2:0] CFG_RATE_HIGH  = 3'd1;
    localparam logic [2:0] CFG_FIRE_MAX   = 3'd2;
    localparam logic [2:0] CFG_FIRE_MIN   = 3'd3;
    localparam logic [2:0] CFG_HOLD_COUNT = 3'd4;
    localparam logic [2:0] CFG_BIAS_STEP  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RATE_W     = 24;
    localparam int BIAS_W     = 8;
    localparam int HOLD_W     = 4;
    localparam int UPD_W      = 2;

    // register reset values
    localparam logic [23:0] RST_RATE_LOW   = 24'd500000;
    localparam logic [23:0] RST_RATE_HIGH  = 24'd2500000;
    localparam logic [7:0]  RST_FIRE_MAX   = 8'd255;
    localparam logic [7:0]  RST_FIRE_MIN   = 8'd0;
    localparam logic [3:0]  RST_HOLD_COUNT = 4'd2;
    localparam logic [7:0]  RST_BIAS_STEP  = 8'd5;

    // bias reset values
    localparam logic [7:0] RST_PHOTO  = 8'd119;
    localparam logic [7:0] RST_FOLLOW = 8'd32;
    localparam logic [7:0] RST_ON_TH  = 8'd63;
    localparam logic [7:0] RST_OFF_TH = 8'd168;

    // bias update codes
    localparam logic [1:0] UPD_NONE = 2'd0;
    localparam logic [1:0] UPD_LOW  = 2'd1;
    localparam logic [1:0] UPD_HIGH = 2'd2;

    // quotient bits resolved by the divider; larger quotients saturate
    localparam int DIV_STEPS = 9;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL_A,
        S_MUL_B,
        S_SUB,
        S_CHK,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul_a;
        logic mul_b;
        logic sub;
        logic chk;
        logic div;
        logic fin;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (b > a) ? 8'h00 : (a - b);
    endfunction

endpackage

// File: src/event_rate_bias_feedback_core.sv
// ----------------------------------------------------------------------------
// event_rate_bias_feedback_core
// Maps a measured event rate onto a clamped refractory bias setting and steps
// four sensor bias values after runs of results pinned at either clamp.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  input    | i_in_valid / o_in_stall    | i_event_rate
//  result   | o_out_valid / i_out_stall  | o_refractory_setting,
//           |                            | o_bias_update, four bias values
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  Steps, set by the sequencer: one prepare step, two multiply steps, a
//  subtract, a range check, nine restoring-divide steps and a final
//  clamp/update step; the result register is loaded at the final step.
//  Reset: synchronous, active low; config returns to its defaults, biases to
//  119/32/63/168, run counters to zero. No memories, no clearing pass.
//  Stalls: the result sits in its own register, so a stalled result only
//  holds the sequencer at its last step; the next word is taken on return
//  to idle.
//
module event_rate_bias_feedback_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [23:0] i_event_rate,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_refractory_setting,
    output logic [1:0]  o_bias_update,
    output logic [7:0]  o_photoreceptor_bias,
    output logic [7:0]  o_follower_bias,
    output logic [7:0]  o_on_threshold_bias,
    output logic [7:0]  o_off_threshold_bias
);

    // sequencer commands and datapath status
    erbf_pkg::t_ctrl_cmd w_cmd;
    erbf_pkg::t_ctrl_sts w_sts;

    erbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // setting = trunc((fmax*den - (fmax-fmin)*(rate-lo)) / den), den = hi-lo,
    // then clamped to fire_max, then to fire_min; if hi <= lo: fire_max below lo, else fire_min
    erbf_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_event_rate         (i_event_rate),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_refractory_setting (o_refractory_setting),
        .o_bias_update        (o_bias_update),
        .o_photoreceptor_bias (o_photoreceptor_bias),
        .o_follower_bias      (o_follower_bias),
        .o_on_threshold_bias  (o_on_threshold_bias),
        .o_off_threshold_bias (o_off_threshold_bias)
    );

endmodule

// File: src/erbf_ctrl.sv
// ----------------------------------------------------------------------------
// erbf_ctrl
// Sequencer: walks each word through prepare, two multiplies, subtract,
// range check, nine divide steps and the final clamp/update.
// ----------------------------------------------------------------------------
module erbf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  erbf_pkg::t_ctrl_sts   i_sts,
    output erbf_pkg::t_ctrl_cmd   o_cmd
);

    erbf_pkg::t_state r_state, n_state;
    logic [erbf_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= erbf_pkg::S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        o_in_stall = (r_state != erbf_pkg::S_IDLE);
        case (r_state)
            erbf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = erbf_pkg::S_PREP;
                end
            end
            erbf_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = erbf_pkg::S_MUL_A;
            end
            erbf_pkg::S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = erbf_pkg::S_MUL_B;
            end
            erbf_pkg::S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = erbf_pkg::S_SUB;
            end
            erbf_pkg::S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = erbf_pkg::S_CHK;
            end
            erbf_pkg::S_CHK: begin
                o_cmd.chk = 1'b1;
                n_div_cnt = '0;
                n_state   = erbf_pkg::S_DIV;
            end
            erbf_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                if (r_div_cnt == erbf_pkg::DIV_CNT_W'(erbf_pkg::DIV_STEPS - 1)) begin
                    n_state = erbf_pkg::S_FIN;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            erbf_pkg::S_FIN: begin
                // wait here while the previous result is still held
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = erbf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = erbf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/erbf_dpath.sv
// ----------------------------------------------------------------------------
// erbf_dpath
// Datapath: config registers, rate mapping arithmetic, restoring divider,
// clamp, run counters, bias levels and the output register.
// ----------------------------------------------------------------------------
module erbf_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [23:0]           i_cfg_data,
    input  logic [23:0]           i_event_rate,
    input  erbf_pkg::t_ctrl_cmd   i_cmd,
    output erbf_pkg::t_ctrl_sts   o_sts,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_refractory_setting,
    output logic [1:0]            o_bias_update,
    output logic [7:0]            o_photoreceptor_bias,
    output logic [7:0]            o_follower_bias,
    output logic [7:0]            o_on_threshold_bias,
    output logic [7:0]            o_off_threshold_bias
);

    // configuration
    logic [23:0] r_rate_low, r_rate_high;
    logic [7:0]  r_fire_max, r_fire_min, r_bias_step;
    logic [3:0]  r_hold_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_low   <= erbf_pkg::RST_RATE_LOW;
            r_rate_high  <= erbf_pkg::RST_RATE_HIGH;
            r_fire_max   <= erbf_pkg::RST_FIRE_MAX;
            r_fire_min   <= erbf_pkg::RST_FIRE_MIN;
            r_hold_count <= erbf_pkg::RST_HOLD_COUNT;
            r_bias_step  <= erbf_pkg::RST_BIAS_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                erbf_pkg::CFG_RATE_LOW:   r_rate_low   <= i_cfg_data;
                erbf_pkg::CFG_RATE_HIGH:  r_rate_high  <= i_cfg_data;
                erbf_pkg::CFG_FIRE_MAX:   r_fire_max   <= i_cfg_data[7:0];
                erbf_pkg::CFG_FIRE_MIN:   r_fire_min   <= i_cfg_data[7:0];
                erbf_pkg::CFG_HOLD_COUNT: r_hold_count <= i_cfg_data[3:0];
                erbf_pkg::CFG_BIAS_STEP:  r_bias_step  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // arithmetic pipeline registers (payload, no reset)
    logic [23:0]        r_rate;
    logic [23:0]        r_den;
    logic               r_empty, r_below;
    logic signed [24:0] r_d;
    logic signed [8:0]  r_fd;
    logic [31:0]        r_prod_a;
    logic signed [33:0] r_prod_b;
    logic               r_neg;
    logic [32:0]        r_mag;
    logic               r_sat;
    logic [24:0]        r_rem;
    logic [8:0]         r_low;
    logic [8:0]         r_quo;

    logic signed [34:0] w_num;
    logic signed [34:0] w_num_neg;
    logic [24:0]        w_trial;
    logic [25:0]        w_diff;
    logic               w_ge;

    assign w_num     = $signed({3'b000, r_prod_a}) - $signed({r_prod_b[33], r_prod_b});
    assign w_num_neg = 35'sd0 - w_num;
    assign w_trial   = {r_rem[23:0], r_low[8]};
    assign w_diff    = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge      = !w_diff[25];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rate <= i_event_rate;
        end
        if (i_cmd.prep) begin
            r_den   <= r_rate_high - r_rate_low;
            r_empty <= !(r_rate_high > r_rate_low);
            r_below <= (r_rate < r_rate_low);
            r_d     <= $signed({1'b0, r_rate}) - $signed({1'b0, r_rate_low});
            r_fd    <= $signed({1'b0, r_fire_max}) - $signed({1'b0, r_fire_min});
        end
        if (i_cmd.mul_a) begin
            r_prod_a <= r_fire_max * r_den;
        end
        if (i_cmd.mul_b) begin
            r_prod_b <= r_fd * r_d;
        end
        if (i_cmd.sub) begin
            r_neg <= w_num[34];
            r_mag <= w_num[34] ? w_num_neg[32:0] : w_num[32:0];
        end
        if (i_cmd.chk) begin
            // quotient of 512 or more only ever clamps, so it saturates
            r_sat <= (r_mag >= {r_den, 9'd0});
            r_rem <= {1'b0, r_mag[32:9]};
            r_low <= r_mag[8:0];
            r_quo <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= w_ge ? w_diff[24:0] : w_trial;
            r_low <= {r_low[7:0], 1'b0};
            r_quo <= {r_quo[7:0], w_ge};
        end
    end

    // mapping, clamp and pinning
    logic [8:0]        w_q;
    logic signed [9:0] w_qs, w_map, w_v1, w_v2, w_fmax_s, w_fmin_s;
    logic              w_pin_hi, w_pin_lo;
    logic [3:0]        w_c_hi, w_c_lo;
    logic              w_step_hi, w_step_lo;

    assign w_q       = r_sat ? 9'h1FF : r_quo;
    assign w_qs      = r_neg ? $signed(10'd0 - {1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_fmax_s  = $signed({2'b00, r_fire_max});
    assign w_fmin_s  = $signed({2'b00, r_fire_min});
    assign w_map     = r_empty ? (r_below ? w_fmax_s : w_fmin_s) : w_qs;
    assign w_v1      = (w_map > w_fmax_s) ? w_fmax_s : w_map;
    assign w_v2      = (w_v1 < w_fmin_s) ? w_fmin_s : w_v1;
    assign w_pin_hi  = (w_v2 == w_fmax_s);
    assign w_pin_lo  = !w_pin_hi && (w_v2 == w_fmin_s);

    // run state and bias levels
    logic [3:0] r_hi_run, r_lo_run, n_hi_run, n_lo_run;
    logic [7:0] r_photo, r_follow, r_on_th, r_off_th;
    logic [7:0] n_photo, n_follow, n_on_th, n_off_th;
    logic [1:0] n_update;

    assign w_c_hi    = r_hi_run + 4'd1;
    assign w_c_lo    = r_lo_run + 4'd1;
    assign w_step_hi = (w_c_hi >= r_hold_count);
    assign w_step_lo = (w_c_lo >= r_hold_count);

    always_comb begin
        n_hi_run = r_hi_run;
        n_lo_run = r_lo_run;
        n_photo  = r_photo;
        n_follow = r_follow;
        n_on_th  = r_on_th;
        n_off_th = r_off_th;
        n_update = erbf_pkg::UPD_NONE;
        if (w_pin_hi) begin
            n_hi_run = w_step_hi ? 4'd0 : w_c_hi;
            if (w_step_hi) begin
                n_photo  = erbf_pkg::sat_add(r_photo, r_bias_step);
                n_follow = erbf_pkg::sat_add(r_follow, r_bias_step);
                n_on_th  = erbf_pkg::sat_sub(r_on_th, r_bias_step);
                n_off_th = erbf_pkg::sat_add(r_off_th, r_bias_step);
                n_update = erbf_pkg::UPD_LOW;
            end
        end else if (w_pin_lo) begin
            n_lo_run = w_step_lo ? 4'd0 : w_c_lo;
            if (w_step_lo) begin
                n_photo  = erbf_pkg::sat_sub(r_photo, r_bias_step);
                n_follow = erbf_pkg::sat_sub(r_follow, r_bias_step);
                n_on_th  = erbf_pkg::sat_add(r_on_th, r_bias_step);
                n_off_th = erbf_pkg::sat_sub(r_off_th, r_bias_step);
                n_update = erbf_pkg::UPD_HIGH;
            end
        end else begin
            n_hi_run = '0;
            n_lo_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_run <= '0;
            r_lo_run <= '0;
            r_photo  <= erbf_pkg::RST_PHOTO;
            r_follow <= erbf_pkg::RST_FOLLOW;
            r_on_th  <= erbf_pkg::RST_ON_TH;
            r_off_th <= erbf_pkg::RST_OFF_TH;
        end else if (i_cmd.fin) begin
            r_hi_run <= n_hi_run;
            r_lo_run <= n_lo_run;
            r_photo  <= n_photo;
            r_follow <= n_follow;
            r_on_th  <= n_on_th;
            r_off_th <= n_off_th;
        end
    end

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_setting;
    logic [1:0] r_out_update;
    logic [7:0] r_out_photo, r_out_follow, r_out_on_th, r_out_off_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_setting <= w_v2[7:0];
            r_out_update  <= n_update;
            r_out_photo   <= n_photo;
            r_out_follow  <= n_follow;
            r_out_on_th   <= n_on_th;
            r_out_off_th  <= n_off_th;
        end
    end

    assign o_sts.out_free       = !r_out_valid || !i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_refractory_setting = r_out_setting;
    assign o_bias_update        = r_out_update;
    assign o_photoreceptor_bias = r_out_photo;
    assign o_follower_bias      = r_out_follow;
    assign o_on_threshold_bias  = r_out_on_th;
    assign o_off_threshold_bias = r_out_off_th;

endmodule

// File: src/erbf_checker.sv
// ----------------------------------------------------------------------------
// erbf_checker
// Port-level checks for the event-rate bias feedback core, bound to the top.
// ----------------------------------------------------------------------------
module erbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall
);

    // a stalled result word is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    // an accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again before previous word finished");

    // a result only appears out of a word in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no word in progress");

    // reset leaves the block empty and ready
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");

endmodule

bind event_rate_bias_feedback_core erbf_checker u_erbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
